FILE: sv/assert_macros.svh
// Assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// hold: whenever a is seen, c holds in the same cycle
`define ASSERT_HOLD(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");
// hold: whenever a is seen, c holds in the next cycle
`define ASSERT_NEXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: sv/ffa_pkg.sv
// Constants and types of the first-fit free-list allocator
package ffa_pkg;
   localparam int HEAP_UNITS = 4096;
   localparam int IDX_W      = $clog2(HEAP_UNITS);
   localparam int SIZE_W     = IDX_W + 1;
   localparam int STEP_W     = IDX_W + 1;

   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_ALLOC   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_BADADDR = 2'd2;
   localparam logic [1:0] ST_NOTINIT = 2'd3;

   localparam logic [2:0] REG_HEAP_BASE  = 3'd0;
   localparam logic [2:0] REG_HEAP_BYTES = 3'd4;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SIZE_W-1:0] size_type;
endpackage

FILE: sv/first_fit_free_list_allocator_top.sv
// Top level of the first-fit free-list allocator
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_opcode, req_request_bytes, req_release_addr
//   rsp     | out       | rsp_valid/rsp_stall | rsp_block_addr, rsp_status
//   csr     | in        | APB psel/penable    | heap_base, heap_bytes
//
// One item at a time: a request is taken only in the idle state. Initialise, and answers
// decided at acceptance, go straight to the finish state; allocate visits free blocks from
// the rover, with a split step when the block is larger; release checks the block size and,
// if the list is not empty, walks it to insert the block, failing at the walk bound.
// One header read per cycle on the shared read address of the two header memories.
// No clearing pass after reset. A stalled result holds the block in its finish state.
`include "assert_macros.svh"
module first_fit_free_list_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_release_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_block_addr,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ffa_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_A_NXT = 4'd1;
   localparam logic [3:0] S_A_EV  = 4'd2;
   localparam logic [3:0] S_A_SPL = 4'd3;
   localparam logic [3:0] S_R_SZ  = 4'd4;
   localparam logic [3:0] S_R_EV  = 4'd5;
   localparam logic [3:0] S_R_NX  = 4'd6;
   localparam logic [3:0] S_R_WL  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HEAP_UNITS);

   size_type size_mem [HEAP_UNITS];
   idx_type  next_mem [HEAP_UNITS];

   logic [3:0]        state_ff, state_in;
   logic [31:0]       base_ff;
   logic [15:0]       bytes_ff;
   idx_type           rover_ff, rover_in;
   logic              nonempty_ff, nonempty_in;
   logic              ready_ff, ready_in;
   idx_type           p_ff, p_in, prev_ff, prev_in, bp_ff, bp_in, nx_ff, nx_in;
   size_type          psz_ff, psz_in, bsz_ff, bsz_in, nbsz_ff, nbsz_in;
   idx_type           nbnext_ff, nbnext_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [29:0]       need_ff, need_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_addr_ff;
   logic [1:0]        rsp_st_ff;

   size_type          size_rd_ff;
   idx_type           next_rd_ff;
   idx_type           rd_addr;
   logic              size_we, next_we;
   idx_type           size_wa, next_wa;
   size_type          size_wd;
   idx_type           next_wd;

   logic              req_acc, cfg_wr, out_free;
   logic [16:0]       bytes_up;
   logic [13:0]       units_raw;
   size_type          units;
   logic [31:0]       off;
   logic [28:0]       bp_wide;
   logic              found;
   size_type          rest;
   logic [13:0]       up_sum, lo_sum;
   logic [31:0]       p_addr;

   assign pready    = 1'b1;
   assign cfg_wr    = psel & penable & pwrite;
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_addr = rsp_addr_ff;
   assign rsp_status     = rsp_st_ff;

   always_comb begin
      unique case (paddr)
         REG_HEAP_BASE:  prdata = base_ff;
         REG_HEAP_BYTES: prdata = {16'd0, bytes_ff};
         default:        prdata = 32'd0;
      endcase
   end

   assign bytes_up  = {1'b0, bytes_ff} + 17'd7;
   assign units_raw = bytes_up[16:3];
   assign units     = (units_raw > 14'(HEAP_UNITS)) ? SIZE_W'(HEAP_UNITS)
                                                    : units_raw[SIZE_W-1:0];
   assign off       = req_release_addr - base_ff;
   assign bp_wide   = off[31:3] - 29'd1;
   assign found     = ((bp_ff > p_ff) && (bp_ff < next_rd_ff)) ||
                      ((p_ff >= next_rd_ff) && ((bp_ff > p_ff) || (bp_ff < next_rd_ff)));
   assign rest      = size_rd_ff - need_ff[SIZE_W-1:0];
   assign up_sum    = {2'd0, bp_ff} + {1'b0, bsz_ff};
   assign lo_sum    = {2'd0, p_ff} + {1'b0, psz_ff};
   assign p_addr    = base_ff + {16'd0, ({1'b0, p_ff} + 13'd1), 3'd0};

   always_comb begin
      state_in    = state_ff;
      rover_in    = rover_ff;
      nonempty_in = nonempty_ff;
      ready_in    = ready_ff;
      p_in        = p_ff;
      prev_in     = prev_ff;
      bp_in       = bp_ff;
      nx_in       = nx_ff;
      psz_in      = psz_ff;
      bsz_in      = bsz_ff;
      nbsz_in     = nbsz_ff;
      nbnext_in   = nbnext_ff;
      steps_in    = steps_ff;
      need_in     = need_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      rd_addr     = p_ff;
      size_we     = 1'b0;
      next_we     = 1'b0;
      size_wa     = p_ff;
      next_wa     = p_ff;
      size_wd     = size_rd_ff;
      next_wd     = next_rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               res_addr_in = 32'd0;
               res_st_in   = ST_OK;
               state_in    = S_DONE;
               need_in     = 30'(req_request_bytes[31:3]) + 30'(|req_request_bytes[2:0])
                             + 30'd1;
               priority if (req_opcode == OP_INIT) begin
                  rover_in    = '0;
                  ready_in    = 1'b1;
                  nonempty_in = (units != '0);
                  size_we     = (units != '0);
                  next_we     = (units != '0);
                  size_wa     = '0;
                  next_wa     = '0;
                  size_wd     = units;
                  next_wd     = '0;
               end else if (req_opcode == OP_ALLOC || req_opcode == OP_RELEASE) begin
                  if (!ready_ff) begin
                     res_st_in = ST_NOTINIT;
                  end else if (req_opcode == OP_ALLOC) begin
                     if (!nonempty_ff) begin
                        res_st_in = ST_NOFIT;
                     end else begin
                        rd_addr  = rover_ff;
                        prev_in  = rover_ff;
                        steps_in = '0;
                        state_in = S_A_NXT;
                     end
                  end else begin
                     if (off[2:0] != 3'd0 || off[31:3] == 29'd0 ||
                         bp_wide >= 29'(units)) begin
                        res_st_in = ST_BADADDR;
                     end else begin
                        bp_in    = bp_wide[IDX_W-1:0];
                        rd_addr  = bp_wide[IDX_W-1:0];
                        state_in = S_R_SZ;
                     end
                  end
               end else begin
                  res_st_in = ST_OK;
               end
            end
         end
         S_A_NXT: begin
            p_in     = next_rd_ff;
            rd_addr  = next_rd_ff;
            state_in = S_A_EV;
         end
         S_A_EV: begin
            if ({17'd0, size_rd_ff} >= need_ff) begin
               rover_in  = prev_ff;
               res_st_in = ST_OK;
               if ({17'd0, size_rd_ff} == need_ff) begin
                  if (p_ff == prev_ff) begin
                     nonempty_in = 1'b0;
                  end else begin
                     next_we = 1'b1;
                     next_wa = prev_ff;
                     next_wd = next_rd_ff;
                  end
                  res_addr_in = p_addr;
                  state_in    = S_DONE;
               end else begin
                  size_we  = 1'b1;
                  size_wa  = p_ff;
                  size_wd  = rest;
                  p_in     = p_ff + rest[IDX_W-1:0];
                  state_in = S_A_SPL;
               end
            end else if (p_ff == rover_ff || steps_ff == STEP_LAST) begin
               res_st_in = ST_NOFIT;
               state_in  = S_DONE;
            end else begin
               prev_in  = p_ff;
               p_in     = next_rd_ff;
               rd_addr  = next_rd_ff;
               steps_in = steps_ff + 1'b1;
            end
         end
         S_A_SPL: begin
            size_we     = 1'b1;
            size_wa     = p_ff;
            size_wd     = need_ff[SIZE_W-1:0];
            res_addr_in = p_addr;
            state_in    = S_DONE;
         end
         S_R_SZ: begin
            bsz_in = size_rd_ff;
            if (size_rd_ff == '0 || size_rd_ff > (units - {1'b0, bp_ff})) begin
               res_st_in = ST_BADADDR;
               state_in  = S_DONE;
            end else if (!nonempty_ff) begin
               next_we     = 1'b1;
               next_wa     = bp_ff;
               next_wd     = bp_ff;
               rover_in    = bp_ff;
               nonempty_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               rd_addr  = rover_ff;
               p_in     = rover_ff;
               steps_in = '0;
               state_in = S_R_EV;
            end
         end
         S_R_EV: begin
            if (found) begin
               nx_in    = next_rd_ff;
               psz_in   = size_rd_ff;
               rd_addr  = next_rd_ff;
               state_in = S_R_NX;
            end else if (steps_ff == STEP_LAST) begin
               res_st_in = ST_BADADDR;
               state_in  = S_DONE;
            end else begin
               p_in     = next_rd_ff;
               rd_addr  = next_rd_ff;
               steps_in = steps_ff + 1'b1;
            end
         end
         S_R_NX: begin
            next_we = 1'b1;
            next_wa = bp_ff;
            size_wa = bp_ff;
            if (up_sum == {2'd0, nx_ff}) begin
               size_we   = 1'b1;
               size_wd   = bsz_ff + size_rd_ff;
               next_wd   = next_rd_ff;
               nbsz_in   = bsz_ff + size_rd_ff;
               nbnext_in = next_rd_ff;
            end else begin
               next_wd   = nx_ff;
               nbsz_in   = bsz_ff;
               nbnext_in = nx_ff;
            end
            state_in = S_R_WL;
         end
         S_R_WL: begin
            next_we = 1'b1;
            next_wa = p_ff;
            size_wa = p_ff;
            if (lo_sum == {2'd0, bp_ff}) begin
               size_we = 1'b1;
               size_wd = psz_ff + nbsz_ff;
               next_wd = nbnext_ff;
            end else begin
               next_wd = bp_ff;
            end
            rover_in  = p_ff;
            res_st_in = ST_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      size_rd_ff <= size_mem[rd_addr];
      next_rd_ff <= next_mem[rd_addr];
      if (size_we) begin
         size_mem[size_wa] <= size_wd;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rover_ff     <= '0;
         nonempty_ff  <= 1'b0;
         ready_ff     <= 1'b0;
         base_ff      <= 32'd0;
         bytes_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rover_ff    <= rover_in;
         nonempty_ff <= nonempty_in;
         ready_ff    <= ready_in;
         if (cfg_wr && paddr == REG_HEAP_BASE) begin
            base_ff <= pwdata;
         end
         if (cfg_wr && paddr == REG_HEAP_BYTES) begin
            bytes_ff <= pwdata[15:0];
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      prev_ff     <= prev_in;
      bp_ff       <= bp_in;
      nx_ff       <= nx_in;
      psz_ff      <= psz_in;
      bsz_ff      <= bsz_in;
      nbsz_ff     <= nbsz_in;
      nbnext_ff   <= nbnext_in;
      steps_ff    <= steps_in;
      need_ff     <= need_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_addr_ff <= res_addr_ff;
         rsp_st_ff   <= res_st_ff;
      end
   end

   `ASSERT_HOLD(a_walk_bound, state_ff == S_A_EV || state_ff == S_R_EV, steps_ff <= STEP_LAST)
   `ASSERT_NEXT(a_done_to_rsp, state_ff == S_DONE && out_free, rsp_valid_ff && state_ff == S_IDLE)
   `ASSERT_HOLD(a_empty_only_alloc, nonempty_ff && !nonempty_in, state_ff == S_A_EV || state_ff == S_IDLE)
endmodule

FILE: verif/ffa_scoreboard.sv
// Heap-state predictor and result comparator for the first-fit allocator
`timescale 1ns / 100ps
module ffa_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_release_addr,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_block_addr,
   input  logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count
);
   import ffa_pkg::*;

   typedef struct packed {
      logic [31:0] block_addr;
      logic [1:0]  status;
   } alloc_result_type;

   size_type         hdr_size [HEAP_UNITS];
   idx_type          hdr_next [HEAP_UNITS];
   idx_type          rover;
   logic             list_live;
   logic             heap_live;
   logic [31:0]      base_reg;
   logic [15:0]      bytes_reg;
   alloc_result_type pending_results [$];

   function automatic int unsigned size_at(int unsigned i);
      return i < HEAP_UNITS ? int'(hdr_size[i]) : 0;
   endfunction

   function automatic int unsigned next_at(int unsigned i);
      return i < HEAP_UNITS ? int'(hdr_next[i]) : 0;
   endfunction

   function automatic void set_size(int unsigned i, int unsigned v);
      if (i < HEAP_UNITS) hdr_size[i] = size_type'(v);
   endfunction

   function automatic void set_next(int unsigned i, int unsigned v);
      if (i < HEAP_UNITS) hdr_next[i] = idx_type'(v);
   endfunction

   function automatic int unsigned heap_unit_count();
      int unsigned u;
      u = (int'(bytes_reg) + 7) / 8;
      return u > HEAP_UNITS ? HEAP_UNITS : u;
   endfunction

   function automatic void take_block(input logic [31:0] req, output logic [31:0] addr,
                                      output logic [1:0] st);
      longint unsigned need;
      int unsigned     prev, p, sz, rest;
      need = (longint'(req) + 7) / 8 + 1;
      prev = rover;
      p    = next_at(prev);
      addr = '0;
      st   = ST_NOFIT;
      if (!list_live) return;
      for (int steps = 0; steps <= HEAP_UNITS; steps++) begin
         sz = size_at(p);
         if (longint'(sz) >= need) begin
            if (longint'(sz) == need) begin
               if (p == prev) list_live = 1'b0;
               else set_next(prev, next_at(p));
            end else begin
               rest = sz - int'(need);
               set_size(p, rest);
               p = p + rest;
               set_size(p, int'(need));
            end
            rover = idx_type'(prev);
            addr  = base_reg + (p + 1) * 8;
            st    = ST_OK;
            return;
         end
         if (p == rover) return;
         prev = p;
         p    = next_at(p);
      end
   endfunction

   function automatic logic [1:0] give_back(input logic [31:0] addr);
      logic [31:0] off;
      int unsigned u, bp, bsz, p, nx;
      logic        found;
      off   = addr - base_reg;
      u     = heap_unit_count();
      found = 1'b0;
      if (off[2:0] != 3'd0 || off[31:3] == '0) return ST_BADADDR;
      bp = off[31:3] - 1;
      if (bp >= u) return ST_BADADDR;
      bsz = size_at(bp);
      if (bsz == 0 || bsz > u - bp) return ST_BADADDR;
      if (!list_live) begin
         set_next(bp, bp);
         rover     = idx_type'(bp);
         list_live = 1'b1;
         return ST_OK;
      end
      p = rover;
      for (int steps = 0; steps <= HEAP_UNITS; steps++) begin
         nx = next_at(p);
         if ((bp > p && bp < nx) || (p >= nx && (bp > p || bp < nx))) begin
            found = 1'b1;
            break;
         end
         p = nx;
      end
      if (!found) return ST_BADADDR;
      nx = next_at(p);
      if (bp + bsz == nx) begin
         set_size(bp, bsz + size_at(nx));
         set_next(bp, next_at(nx));
      end else begin
         set_next(bp, nx);
      end
      if (p + size_at(p) == bp) begin
         set_size(p, size_at(p) + size_at(bp));
         set_next(p, next_at(bp));
      end else begin
         set_next(p, bp);
      end
      rover = idx_type'(p);
      return ST_OK;
   endfunction

   function automatic alloc_result_type predict_result(logic [1:0] op, logic [31:0] req,
                                                       logic [31:0] rel);
      alloc_result_type r;
      int unsigned      u;
      r = '0;
      if (op == OP_INIT) begin
         u         = heap_unit_count();
         rover     = '0;
         heap_live = 1'b1;
         list_live = u != 0;
         if (u != 0) begin
            set_size(0, u);
            set_next(0, 0);
         end
      end else if (op == OP_ALLOC || op == OP_RELEASE) begin
         if (!heap_live) r.status = ST_NOTINIT;
         else if (op == OP_ALLOC) take_block(req, r.block_addr, r.status);
         else r.status = give_back(rel);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (reset) begin
         foreach (hdr_size[i]) begin
            hdr_size[i] = '0;
            hdr_next[i] = '0;
         end
         rover      = '0;
         list_live  = 1'b0;
         heap_live  = 1'b0;
         base_reg   = '0;
         bytes_reg  = '0;
         fail_count = 0;
         pending_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == REG_HEAP_BASE) base_reg = pwdata;
            else if (paddr == REG_HEAP_BYTES) bytes_reg = pwdata[15:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected item: addr %h status %0d", rsp_block_addr, rsp_status);
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_block_addr !== exp_r.block_addr || rsp_status !== exp_r.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                              exp_r.block_addr, exp_r.status, rsp_block_addr, rsp_status);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(predict_result(req_opcode, req_request_bytes,
                                                     req_release_addr));
      end
   end
endmodule

FILE: verif/tb_first_fit_free_list_allocator_top.sv
// Stimulus and verdict for the first-fit free-list allocator
`timescale 1ns / 100ps
module tb_first_fit_free_list_allocator_top;
   import ffa_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_INIT;
   logic [31:0] req_request_bytes = '0;
   logic [31:0] req_release_addr = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_block_addr;
   logic [1:0]  rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;

   int          cycle_count = 0;
   int          items_sent = 0;
   int          items_back = 0;
   logic        quiet_mode = 1'b0;
   logic [31:0] cur_base = '0;
   logic [15:0] cur_bytes = '0;
   logic [1:0]  ops_in_flight [$];
   int unsigned live_units [$];
   int unsigned freed_units [$];

   first_fit_free_list_allocator_top u_dut (.*);

   ffa_scoreboard u_scoreboard (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_first_fit_free_list_allocator_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic [1:0] op;
      if (!reset && rsp_valid && !rsp_stall) begin
         items_back <= items_back + 1;
         op = ops_in_flight.pop_front();
         if (op == OP_INIT) live_units.delete();
         if (op == OP_ALLOC && rsp_status == ST_OK)
            live_units.push_back((rsp_block_addr - cur_base) / 8 - 1);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (cycle_count == 4000) begin
            rsp_stall <= 1'b1;
            hold = 0;
            while (hold < 400) begin
               @(posedge clock);
               hold++;
            end
         end
         if ($urandom_range(0, 199) == 0) quiet_mode <= ~quiet_mode;
         rsp_stall <= (pick_gap() > 0);
      end
   end

   task automatic send_item(logic [1:0] op, logic [31:0] req, logic [31:0] rel);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_request_bytes <= req;
      req_release_addr  <= rel;
      do @(posedge clock); while (req_stall);
      ops_in_flight.push_back(op);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (items_back != items_sent) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_heap(logic [31:0] base, logic [15:0] bytes);
      wait_idle();
      csr_write(REG_HEAP_BASE, base);
      csr_write(REG_HEAP_BYTES, {16'(~bytes), bytes});
      cur_base  = base;
      cur_bytes = bytes;
   endtask

   function automatic logic [31:0] unit_addr(int unsigned unit);
      return cur_base + (unit + 1) * 8;
   endfunction

   function automatic logic [31:0] noise_addr();
      logic [31:0] a;
      a = $urandom;
      if (a[2:0] == cur_base[2:0]) a[0] = ~a[0];
      return a;
   endfunction

   task automatic run_mix(int n);
      int          r, k;
      int unsigned unit;
      logic [31:0] req;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55 || (r < 90 && live_units.size() == 0)) begin
            k = $urandom_range(0, 99);
            if (k < 85) req = $urandom_range(0, cur_bytes / 6 + 1);
            else if (k < 95) req = $urandom_range(0, cur_bytes);
            else req = $urandom;
            send_item(OP_ALLOC, req, $urandom);
         end else if (r < 90) begin
            k    = $urandom_range(0, live_units.size() - 1);
            unit = live_units[k];
            live_units.delete(k);
            freed_units.push_back(unit);
            send_item(OP_RELEASE, $urandom, unit_addr(unit));
         end else if (r < 94) begin
            send_item(OP_RELEASE, $urandom, noise_addr());
         end else if (r < 96 && freed_units.size() > 0) begin
            unit = freed_units[$urandom_range(0, freed_units.size() - 1)];
            send_item(OP_RELEASE, $urandom, unit_addr(unit));
         end else if (r < 98) begin
            send_item(OP_RELEASE, $urandom,
                      cur_base + 8 * ($urandom_range(0, 3) == 0 ? 0 :
                                      ((cur_bytes + 7) / 8 + $urandom_range(1, 9))));
         end else if (r < 99) begin
            wait_idle();
            send_item(OP_INIT, $urandom, $urandom);
            wait_idle();
         end else begin
            send_item(2'd3, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      int unsigned unit;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_ALLOC, 32'd8, '0);
      send_item(OP_RELEASE, '0, 32'd16);
      send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_INIT, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_RELEASE, '0, 32'd8);
      set_heap(32'h0, 16'd64);
      send_item(OP_INIT, '0, '0);
      send_item(OP_ALLOC, 32'd56, '0);
      send_item(OP_ALLOC, 32'd0, '0);
      wait_idle();
      unit = live_units[0];
      send_item(OP_RELEASE, '0, unit_addr(unit));
      send_item(OP_ALLOC, 32'd0, '0);
      send_item(OP_ALLOC, 32'hFFFF_FFFF, '0);
      send_item(OP_ALLOC, 32'd9, '0);
      send_item(OP_RELEASE, '0, 32'd12);
      send_item(OP_RELEASE, '0, 32'd0);
      send_item(OP_RELEASE, '0, 32'd200);
      wait_idle();
      send_item(OP_RELEASE, '0, unit_addr(live_units[0]));
      send_item(OP_RELEASE, '0, unit_addr(live_units[0]));
      send_item(OP_RELEASE, '0, unit_addr(live_units[1]));
      send_item(OP_ALLOC, 32'd48, '0);

      set_heap(32'hFFFF_FFF0, 16'hFFFF);
      send_item(OP_INIT, '0, '0);
      run_mix(150);
      set_heap(32'h1000_0003, 16'd13);
      send_item(OP_INIT, '0, '0);
      run_mix(100);
      set_heap($urandom & 32'hFFFF_FFF8, 16'd2048);
      send_item(OP_INIT, '0, '0);
      run_mix(300);
      set_heap(32'h0, 16'd512);
      send_item(OP_INIT, '0, '0);
      run_mix(300);
      set_heap(32'hFFFF_FFFF, 16'd32768);
      send_item(OP_INIT, '0, '0);
      run_mix(150);

      wait_idle();
      if (fail_count == 0) begin
         $display("tb_first_fit_free_list_allocator_top OK");
      end else begin
         $display("tb_first_fit_free_list_allocator_top NOT OK");
      end
      $finish;
   end
endmodule
